// File: hdl/svwt_pkg.sv
// ----------------------------------------------------------------------------
// svwt_pkg: shared types and constants for the wavetable/PCM voice engine
// Function codes and fixed constants of the voice engine.
// ----------------------------------------------------------------------------
package svwt_pkg;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_ROM   = 2'd2,
        FUNC_TICK  = 2'd3
    } func_t;

    localparam int RAM_ABITS = 13;
    localparam int VOL_UNIT  = 2 * 32 * 256 / 30;
    localparam int SUM_W     = 25;

endpackage

// File: hdl/svwt_ram.sv
// ----------------------------------------------------------------------------
// svwt_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module svwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/sixteen_voice_wavetable_pcm_synth_core.sv
// ----------------------------------------------------------------------------
// sixteen_voice_wavetable_pcm_synth_core: 16-voice wavetable/PCM generator
// Register/wave RAM, shadow RAM, PCM ROM and per-voice position RAMs.
// ----------------------------------------------------------------------------
// ROM loads go straight to ST_OUT; reads pass ST_RD and ST_WR0, writes ST_WR0 and
// ST_WR1. A tick visits each voice in turn, reading six bytes through the single read
// port of the register RAM, and a voice with key on goes on to mix one sample.
// One request in flight; the next is accepted the cycle after the result is taken.
// After reset a clearing pass zeroes all 8192 entries of register and shadow
// RAM and the position RAMs; no request is accepted during it.
module sixteen_voice_wavetable_pcm_synth_core
    import svwt_pkg::*;
#(
    parameter int VOICES        = 16,
    parameter int ROM_ADDR_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[1:0], address[14:2], data[30:15], rom_address[50:31], rom_byte[58:51]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[15:0], left_sum[40:16], right_sum[65:41]
    output logic [71:0] m_tdata
);
    localparam int VB = (VOICES > 1) ? $clog2(VOICES) : 1;

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_RD, ST_WR0, ST_WR1, ST_T0, ST_T1, ST_T2,
        ST_T3, ST_T4, ST_T5, ST_T6, ST_T7, ST_T8, ST_T9, ST_OUT
    } state_t;

    state_t state_reg;
    logic [RAM_ABITS-1:0] cnt_reg;
    logic [1:0] func_reg;
    logic [RAM_ABITS-1:0] addr_reg;
    logic [15:0] data_reg;
    logic [VB-1:0] v_reg;
    logic [7:0] r0_reg, r1_reg, r2_reg, r3_reg, r4_reg, r5_reg, vol_reg;
    logic [31:0] pos_reg, epos_reg;
    logic signed [SUM_W-1:0] sl_reg, sr_reg;
    logic [15:0] rd_reg;
    logic [2:0] sub_reg;

    // register RAM
    logic ram_we; logic [RAM_ABITS-1:0] ram_wa, ram_ra; logic [7:0] ram_wd, ram_rd;
    svwt_ram #(.WIDTH(8), .DEPTH(8192)) u_ram (.aclk, .we(ram_we), .waddr(ram_wa),
        .wdata(ram_wd), .raddr(ram_ra), .rdata(ram_rd));
    logic sh_we; logic [RAM_ABITS-1:0] sh_wa; logic [7:0] sh_wd, sh_rd;
    svwt_ram #(.WIDTH(8), .DEPTH(8192)) u_sh (.aclk, .we(sh_we), .waddr(sh_wa),
        .wdata(sh_wd), .raddr(ram_ra), .rdata(sh_rd));
    logic rom_we; logic [ROM_ADDR_BITS-1:0] rom_wa, rom_ra; logic [7:0] rom_rd;
    svwt_ram #(.WIDTH(8), .DEPTH(1 << ROM_ADDR_BITS)) u_rom (.aclk, .we(rom_we),
        .waddr(rom_wa), .wdata(s_tdata[58:51]), .raddr(rom_ra), .rdata(rom_rd));
    logic ps_we, es_we; logic [VB-1:0] p_wa; logic [31:0] ps_wd, es_wd, ps_rd, es_rd;
    svwt_ram #(.WIDTH(32), .DEPTH(1 << VB)) u_ps (.aclk, .we(ps_we), .waddr(p_wa),
        .wdata(ps_wd), .raddr(v_reg), .rdata(ps_rd));
    svwt_ram #(.WIDTH(32), .DEPTH(1 << VB)) u_es (.aclk, .we(es_we), .waddr(p_wa),
        .wdata(es_wd), .raddr(v_reg), .rdata(es_rd));

    logic acc;
    assign s_tready = (state_reg == ST_IDLE);
    assign acc = s_tvalid && s_tready;
    assign rom_wa = s_tdata[31 +: ROM_ADDR_BITS];
    assign rom_we = acc && (s_tdata[1:0] == FUNC_ROM);

    logic [RAM_ABITS-1:0] vbase;
    assign vbase = RAM_ABITS'({v_reg, 3'b000});
    logic [RAM_ABITS-1:0] wave_a, env_a;
    logic [17:0] pitch;
    logic [7:0] pstep;
    logic [31:0] pcm_addr, pcm_end;
    logic env_end;
    assign pitch = {2'b00, r3_reg, r2_reg} >> r0_reg[7];
    assign pstep = ((r2_reg >> r0_reg[7]) == 8'd0) ? 8'd4 : (r2_reg >> r0_reg[7]);
    assign pcm_addr = {12'd0, r4_reg, 12'd0} + {4'd0, pos_reg[31:4]};
    assign pcm_end = {11'd0, 9'h100 - {1'b0, r5_reg}, 12'd0};
    assign wave_a = {r1_reg[5:0], 7'd0} + 13'h1000 + {6'd0, pos_reg[16:10]};
    assign env_a = {r5_reg[5:0], 7'd0} + {6'd0, epos_reg[16:10]};
    assign env_end = r0_reg[2] && (epos_reg[31:17] != 15'd0);
    assign rom_ra = pcm_addr[ROM_ADDR_BITS-1:0];

    // product of signed sample and 4-bit volume, scaled
    logic signed [8:0] smp;
    logic signed [SUM_W-1:0] pl, pr;
    assign smp = (r0_reg[1] ? {ram_rd[7], ram_rd} : {rom_rd[7], rom_rd});
    assign pl = SUM_W'(smp * $signed({1'b0, vol_reg[7:4]}) * $signed(15'(VOL_UNIT)));
    assign pr = SUM_W'(smp * $signed({1'b0, vol_reg[3:0]}) * $signed(15'(VOL_UNIT)));

    always_comb begin
        ram_we = 1'b0; ram_wa = addr_reg; ram_wd = data_reg[7:0]; ram_ra = addr_reg;
        sh_we = 1'b0; sh_wa = addr_reg; sh_wd = data_reg[15:8];
        ps_we = 1'b0; es_we = 1'b0; p_wa = v_reg; ps_wd = 32'd0; es_wd = 32'd0;
        case (state_reg)
            ST_CLR: begin
                ram_we = 1'b1; sh_we = 1'b1; ram_wa = cnt_reg; sh_wa = cnt_reg;
                ram_wd = 8'd0; sh_wd = 8'd0;
                ps_we = 1'b1; es_we = 1'b1; p_wa = cnt_reg[VB-1:0];
            end
            ST_WR1: begin
                ram_we = 1'b1; sh_we = 1'b1;
                if ({6'd0, addr_reg[RAM_ABITS-1:3]} < 16'(VOICES) && addr_reg[2:0] == 3'd0
                    && !ram_rd[0] && data_reg[0]) begin
                    ps_we = 1'b1; es_we = 1'b1; p_wa = addr_reg[VB+2:3];
                end
            end
            ST_T0: ram_ra = vbase + RAM_ABITS'(sub_reg);
            ST_T1: ram_ra = vbase + RAM_ABITS'(sub_reg);
            ST_T3: ram_ra = env_a;
            ST_T4: ram_ra = wave_a;
            ST_T5: ram_ra = wave_a;
            ST_T6: begin
                if ((!r0_reg[1] && pcm_addr >= pcm_end) || (r0_reg[1] && env_end)) begin
                    ram_we = 1'b1; ram_wa = vbase; ram_wd = {r0_reg[7:1], 1'b0};
                end else begin
                    ps_we = 1'b1;
                    ps_wd = r0_reg[1] ? pos_reg + {14'd0, pitch} : pos_reg + {24'd0, pstep};
                    es_we = r0_reg[1]; es_wd = epos_reg + {24'd0, r4_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR; cnt_reg <= '0; m_tvalid <= 1'b0;
        end else begin
            case (state_reg)
                ST_CLR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (&cnt_reg) state_reg <= ST_IDLE;
                end
                ST_IDLE: if (acc) begin
                    func_reg <= s_tdata[1:0]; addr_reg <= s_tdata[14:2];
                    data_reg <= s_tdata[30:15];
                    rd_reg <= '0; sl_reg <= '0; sr_reg <= '0; v_reg <= '0; sub_reg <= '0;
                    case (func_t'(s_tdata[1:0]))
                        FUNC_READ:  state_reg <= ST_RD;
                        FUNC_WRITE: state_reg <= ST_WR0;
                        FUNC_TICK:  state_reg <= ST_T0;
                        default:    state_reg <= ST_OUT;
                    endcase
                end
                ST_RD: begin state_reg <= ST_WR0; end
                ST_WR0: begin
                    if (func_reg == FUNC_READ) begin
                        rd_reg <= {sh_rd, ram_rd}; state_reg <= ST_OUT;
                    end else state_reg <= ST_WR1;
                end
                ST_WR1: state_reg <= ST_OUT;
                // T0 issues read of byte sub; T1 captures previous byte
                ST_T0: begin sub_reg <= sub_reg + 1'b1; state_reg <= ST_T1; end
                ST_T1: begin
                    case (sub_reg)
                        3'd1: r0_reg <= ram_rd;
                        3'd2: r1_reg <= ram_rd;
                        3'd3: r2_reg <= ram_rd;
                        3'd4: r3_reg <= ram_rd;
                        3'd5: r4_reg <= ram_rd;
                        default: r5_reg <= ram_rd;
                    endcase
                    if (sub_reg == 3'd6) state_reg <= ST_T2;
                    else state_reg <= ST_T0;
                end
                ST_T2: begin
                    pos_reg <= ps_rd; epos_reg <= es_rd; sub_reg <= '0;
                    state_reg <= r0_reg[0] ? ST_T3 : ST_T8;
                end
                ST_T3: state_reg <= ST_T4;
                ST_T4: begin
                    vol_reg <= r0_reg[1] ? ram_rd : r1_reg; state_reg <= ST_T5;
                end
                ST_T5: state_reg <= ST_T6;
                ST_T6: begin
                    if (!((!r0_reg[1] && pcm_addr >= pcm_end) || (r0_reg[1] && env_end))) begin
                        sl_reg <= sl_reg + pl; sr_reg <= sr_reg + pr;
                    end
                    state_reg <= ST_T8;
                end
                ST_T8: begin
                    if (32'(v_reg) == VOICES - 1) state_reg <= ST_OUT;
                    else begin v_reg <= v_reg + 1'b1; state_reg <= ST_T0; end
                end
                ST_OUT: begin
                    if (!m_tvalid) begin
                        m_tvalid <= 1'b1;
                        m_tdata <= {6'd0, sr_reg, sl_reg, rd_reg};
                    end else if (m_tready) begin
                        m_tvalid <= 1'b0; state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("accept while result pending");
    a_clr_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLR |-> !s_tready) else $error("ready during clear");
    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
`endif
endmodule

// File: bench/tb_sixteen_voice_wavetable_pcm_synth_core.sv
// ----------------------------------------------------------------------------
// tb_sixteen_voice_wavetable_pcm_synth_core: self-checking bench
// Streams reads, writes, ROM loads and sample ticks into the voice engine
// under random bursts and output stalls. Every request is mirrored by a
// local voice model that predicts the result word for the monitor to check.
// ----------------------------------------------------------------------------
module tb_sixteen_voice_wavetable_pcm_synth_core;
    import svwt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NVOICE     = 16;
    localparam int ROM_AMASK  = 32'hFFFFF;
    localparam int CYC_LIMIT  = 3000000;
    localparam int TAIL_WAIT  = 400;
    localparam int RAND_ITEMS = 340;

    typedef struct packed {
        logic [24:0] rsum;
        logic [24:0] lsum;
        logic [15:0] rd;
    } mix_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    sixteen_voice_wavetable_pcm_synth_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // local copy of the engine state
    logic [7:0]  reg_ram    [0:8191];
    logic [7:0]  shadow_ram [0:8191];
    logic [31:0] samp_pos   [0:NVOICE-1];
    logic [31:0] env_pos    [0:NVOICE-1];
    logic [7:0]  rom_img    [int];

    logic [63:0] req_q[$];
    mix_word_t   mix_q[$];
    bit          gen_done = 0;
    int          err_cnt = 0;
    int          n_rd = 0, n_wr = 0, n_rom = 0, n_tick = 0, n_keyoff = 0;
    int          acc_cnt = 0, issued = 0, rcv_cnt = 0;
    int          cyc = 0;

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH result %0d %s: got %h expected %h", rcv_cnt, what, got, want);
        err_cnt++;
    endtask

    task automatic mix_tick(output logic [24:0] lo, output logic [24:0] ro);
        int sl, sr, s;
        logic [7:0] r0, vol;
        logic [31:0] start, endv, addr, step, eidx, wave, env;
        int div;
        sl = 0;
        sr = 0;
        for (int v = 0; v < NVOICE; v++) begin
            r0 = reg_ram[v*8];
            div = r0[7];
            if (!r0[0]) continue;
            if (!r0[1]) begin
                start = {12'd0, reg_ram[v*8+4], 12'd0};
                endv  = (32'd256 - reg_ram[v*8+5]) << 12;
                addr  = start + (samp_pos[v] >> 4);
                step  = reg_ram[v*8+2] >> div;
                if (step == 0) step = 4;
                if (addr >= endv) begin
                    reg_ram[v*8] = r0 & 8'hFE;
                    n_keyoff++;
                    continue;
                end
                s = $signed(rom_img[addr & ROM_AMASK]);
                sl += s * reg_ram[v*8+1][7:4] * VOL_UNIT;
                sr += s * reg_ram[v*8+1][3:0] * VOL_UNIT;
                samp_pos[v] = samp_pos[v] + step;
            end else begin
                wave = (reg_ram[v*8+1] << 7) + 32'h1000;
                env  = reg_ram[v*8+5] << 7;
                step = {reg_ram[v*8+3], reg_ram[v*8+2]} >> div;
                eidx = env_pos[v] >> 10;
                if (r0[2] && eidx >= 32'h80) begin
                    reg_ram[v*8] = r0 & 8'hFE;
                    n_keyoff++;
                    continue;
                end
                vol = reg_ram[(env + (eidx & 32'h7F)) & 32'h1FFF];
                s = $signed(reg_ram[(wave + ((samp_pos[v] >> 10) & 32'h7F)) & 32'h1FFF]);
                sl += s * vol[7:4] * VOL_UNIT;
                sr += s * vol[3:0] * VOL_UNIT;
                samp_pos[v] = samp_pos[v] + step;
                env_pos[v]  = env_pos[v] + reg_ram[v*8+4];
            end
        end
        lo = sl[24:0];
        ro = sr[24:0];
    endtask

    task automatic issue(func_t f, logic [12:0] a, logic [15:0] d,
                         logic [19:0] ra, logic [7:0] rb);
        mix_word_t w;
        w = '0;
        case (f)
            FUNC_READ: begin
                w.rd = {shadow_ram[a], reg_ram[a]};
                n_rd++;
            end
            FUNC_WRITE: begin
                shadow_ram[a] = d[15:8];
                if ((a >> 3) < NVOICE && a[2:0] == 3'd0 && !reg_ram[a][0] && d[0]) begin
                    samp_pos[a>>3] = 0;
                    env_pos[a>>3]  = 0;
                end
                reg_ram[a] = d[7:0];
                n_wr++;
            end
            FUNC_ROM: begin
                rom_img[ra] = rb;
                n_rom++;
            end
            default: begin
                mix_tick(w.lsum, w.rsum);
                n_tick++;
            end
        endcase
        req_q.push_back({5'd0, rb, ra, d, a, f});
        mix_q.push_back(w);
    endtask

    // loads every ROM byte the next tick will fetch that was never written
    task automatic tick_item();
        logic [7:0] r0;
        logic [31:0] addr, endv;
        for (int v = 0; v < NVOICE; v++) begin
            r0 = reg_ram[v*8];
            if (r0[0] && !r0[1]) begin
                addr = {12'd0, reg_ram[v*8+4], 12'd0} + (samp_pos[v] >> 4);
                endv = (32'd256 - reg_ram[v*8+5]) << 12;
                if (addr < endv && !rom_img.exists(addr & ROM_AMASK))
                    issue(FUNC_ROM, 0, 0, addr[19:0], 8'($urandom));
            end
        end
        issue(FUNC_TICK, 0, 0, 0, 0);
    endtask

    task automatic wr(int a, int d);
        issue(FUNC_WRITE, 13'(a), 16'(d), 20'($urandom), 8'($urandom));
    endtask

    task automatic setup_voice(int v, logic [7:0] r0, logic [7:0] r1, logic [7:0] r2,
                               logic [7:0] r3, logic [7:0] r4, logic [7:0] r5);
        wr(v*8+1, {8'($urandom), r1});
        wr(v*8+2, {8'($urandom), r2});
        wr(v*8+3, {8'($urandom), r3});
        wr(v*8+4, {8'($urandom), r4});
        wr(v*8+5, {8'($urandom), r5});
        wr(v*8, {8'($urandom), r0});
    endtask

    initial begin
        int v, k, n, r4, start_cnt;
        logic [7:0] r0;
        for (int i = 0; i < 8192; i++) begin
            reg_ram[i] = 0;
            shadow_ram[i] = 0;
        end
        for (int i = 0; i < NVOICE; i++) begin
            samp_pos[i] = 0;
            env_pos[i] = 0;
        end
        // directed
        issue(FUNC_READ, 13'd0, 0, 0, 0);
        issue(FUNC_READ, 13'h1FFF, 0, 0, 0);
        issue(FUNC_ROM, 0, 0, 20'd0, 8'h00);
        issue(FUNC_ROM, 0, 0, 20'hFFFFF, 8'hFF);
        tick_item();
        wr(13'h1FFF, 16'hFFFF);
        wr(13'h0000, 16'h0000);
        issue(FUNC_READ, 13'h1FFF, 0, 0, 0);
        // zero step becomes 4, full volume
        setup_voice(0, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        tick_item();
        // start equal to end: key drops at once
        setup_voice(1, 8'h01, 8'h5A, 8'h30, 8'h00, 8'h05, 8'd251);
        tick_item();
        issue(FUNC_READ, 13'd8, 0, 0, 0);
        // waveform, divider, wave and envelope numbers wrap past the RAM
        setup_voice(2, 8'h83, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        tick_item();
        tick_item();
        wr(16, 16'h0083);   // key already set: positions keep running
        tick_item();
        start_cnt = req_q.size();
        while (req_q.size() - start_cnt < RAND_ITEMS) begin
            k = $urandom_range(0, 99);
            v = $urandom_range(0, NVOICE-1);
            if (k < 35) begin
                r0 = 8'($urandom) | 8'h01;
                if (!r0[1]) begin
                    r4 = $urandom_range(0, 255);
                    setup_voice(v, r0, 8'($urandom), 8'($urandom), 8'($urandom), 8'(r4),
                                ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 255 - r4)));
                end else
                    setup_voice(v, r0, 8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom));
                n = $urandom_range(1, 8);
                repeat (n) tick_item();
            end else if (k < 50) begin
                n = $urandom_range(1, 6);
                repeat (n) wr($urandom_range(128, 8191), $urandom);
            end else if (k < 62) begin
                issue(FUNC_READ, ($urandom_range(0, 1)) ? 13'($urandom_range(0, 127))
                                                         : 13'($urandom), 0, 0, 0);
            end else if (k < 70) begin
                wr(($urandom_range(0, 1)) ? $urandom_range(0, 127) : $urandom, $urandom);
            end else if (k < 90) begin
                n = $urandom_range(1, 10);
                repeat (n) tick_item();
            end else if (k < 97) begin
                issue(FUNC_ROM, 13'($urandom), 16'($urandom), 20'($urandom), 8'($urandom));
            end else begin
                wr(v*8, 16'($urandom) & 16'hFFFE);
            end
        end
        // silence every voice so the long run below needs no ROM loads
        for (int i = 0; i < NVOICE; i++) wr(i*8, 0);
        // one-shot envelope running to its end
        setup_voice(3, 8'h07, 8'h10, 8'h40, 8'h01, 8'hFF, 8'h22);
        repeat (520) tick_item();
        gen_done = 1;
    end

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // driver: bursts with gaps; issued counts presented requests
    int burst_left = 0, gap_left = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || acc_cnt == issued) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (gen_done && req_q.size() > 0) begin
                s_tdata <= req_q.pop_front();
                s_tvalid <= 1'b1;
                issued++;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 300);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        cyc++;
        if (aresetn && s_tvalid && s_tready) acc_cnt++;
        if (cyc > CYC_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cyc, mix_q.size());
            $display("sixteen_voice_wavetable_pcm_synth_core verification failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off while the sender keeps offering
    int hold_left = 0;
    bit hold_done = 0;
    always @(negedge aclk) begin
        if (!hold_done && rcv_cnt >= 300) begin
            hold_done = 1;
            hold_left = 2000;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rcv_cnt < 100 || (rcv_cnt / 150) % 2 == 1) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge aclk) begin
        mix_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[65:0];
            if (mix_q.size() == 0) begin
                flag_mismatch("unexpected result", got.rd, 0);
            end else begin
                want = mix_q.pop_front();
                if (got.rd !== want.rd) flag_mismatch("read_data", got.rd, want.rd);
                if (got.lsum !== want.lsum) flag_mismatch("left_sum", got.lsum, want.lsum);
                if (got.rsum !== want.rsum) flag_mismatch("right_sum", got.rsum, want.rsum);
            end
            rcv_cnt++;
        end
    end

    initial begin
        wait (gen_done);
        wait (req_q.size() == 0 && acc_cnt == issued && mix_q.size() == 0);
        repeat (TAIL_WAIT) @(posedge aclk);
        if (mix_q.size() != 0) begin
            $display("%0d results never arrived", mix_q.size());
            err_cnt++;
        end
        $display("covered %0d reads, %0d writes, %0d ROM loads, %0d ticks", n_rd, n_wr,
                 n_rom, n_tick);
        $display("%0d voices keyed off by end checks, %0d mismatches", n_keyoff, err_cnt);
        if (err_cnt == 0)
            $display("sixteen_voice_wavetable_pcm_synth_core verification clean");
        else
            $display("sixteen_voice_wavetable_pcm_synth_core verification failed");
        $finish;
    end
endmodule

// File: filelist.f
hdl/svwt_pkg.sv
hdl/svwt_ram.sv
hdl/sixteen_voice_wavetable_pcm_synth_core.sv
bench/tb_sixteen_voice_wavetable_pcm_synth_core.sv
